// ----- rtl/lwsc_pkg.sv -----
`timescale 1ns / 1ps
// lwsc_pkg: sizes, codes and structs shared by the sector cache tag engine
// no dependencies

package lwsc_pkg;

  localparam int SLOTS       = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W      = 6;
  localparam int TAG_W       = 32;
  localparam int TICK_W      = 32;
  localparam int CNT_W       = 32;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_FLUSH_END
  } state_t;

  // token passed from cell to cell during a scan
  typedef struct packed {
    logic              active;
    logic              flush;
    logic [TAG_W-1:0]  sector;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              inv;
    logic [IDX_W-1:0]  inv_idx;
    logic              best_ok;
    logic [IDX_W-1:0]  best_idx;
    logic [TICK_W-1:0] best_tick;
    logic              best_dirty;
    logic [TAG_W-1:0]  best_tag;
  } scan_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic              en;
    logic              miss;
    logic              write;
    logic [IDX_W-1:0]  idx;
    logic [TAG_W-1:0]  tag;
    logic [TICK_W-1:0] tick;
  } upd_t;

  // dirty slot report during flush, all zero when not selected
  typedef struct packed {
    logic             sel;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
  } dirty_t;

endpackage

// ----- rtl/lwsc_if.sv -----
`timescale 1ns / 1ps
// lwsc_in_if / lwsc_out_if: valid/ready channels of the tag engine
// depends on lwsc_pkg for field widths

interface lwsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [lwsc_pkg::TAG_W-1:0]   sector;
  logic [lwsc_pkg::TICK_W-1:0]  current_tick;

  modport source(output valid, func, sector, current_tick, input ready);
  modport sink(input valid, func, sector, current_tick, output ready);
endinterface

interface lwsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [lwsc_pkg::SLOT_W-1:0]  slot;
  logic                         hit;
  logic                         writeback_needed;
  logic [lwsc_pkg::TAG_W-1:0]   writeback_sector;
  logic                         fetch_needed;
  logic                         last;
  logic [lwsc_pkg::CNT_W-1:0]   hit_total;
  logic [lwsc_pkg::CNT_W-1:0]   miss_total;

  modport source(output valid, slot, hit, writeback_needed, writeback_sector,
                 fetch_needed, last, hit_total, miss_total, input ready);
  modport sink(input valid, slot, hit, writeback_needed, writeback_sector,
               fetch_needed, last, hit_total, miss_total, output ready);
endinterface

// ----- rtl/lwsc_cell.sv -----
`timescale 1ns / 1ps
// lwsc_cell: one cache slot (valid, dirty, tag, last use) and its scan stage
// depends on lwsc_pkg

module lwsc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lwsc_pkg::IDX_W-1:0] idx,
  input  logic                       adv,
  input  logic                       room,
  input  lwsc_pkg::scan_t            scan_in,
  output lwsc_pkg::scan_t            scan_out,
  input  lwsc_pkg::upd_t             upd,
  output lwsc_pkg::dirty_t           dirty_rpt
);
  import lwsc_pkg::*;

  logic              valid;
  logic              dirty;
  logic [TAG_W-1:0]  tag;
  logic [TICK_W-1:0] last_use;
  scan_t             scan_next;
  logic              sel;
  logic              upd_here;

  // fold this slot into the passing token
  always_comb begin
    scan_next = scan_in;
    if (scan_in.active && !scan_in.flush && valid && tag == scan_in.sector &&
        !scan_in.hit) begin
      scan_next.hit     = 1'b1;
      scan_next.hit_idx = idx;
    end
    if (scan_in.active && !valid && !scan_in.inv) begin
      scan_next.inv     = 1'b1;
      scan_next.inv_idx = idx;
    end
    if (scan_in.active && valid &&
        (!scan_in.best_ok || last_use < scan_in.best_tick)) begin
      scan_next.best_ok    = 1'b1;
      scan_next.best_idx   = idx;
      scan_next.best_tick  = last_use;
      scan_next.best_dirty = dirty;
      scan_next.best_tag   = tag;
    end
  end

  // flush picks this slot when the token sits here
  assign sel       = scan_in.active && scan_in.flush && valid && dirty && room;
  assign dirty_rpt = sel ? dirty_t'{sel: 1'b1, idx: idx, tag: tag} : dirty_t'('0);
  assign upd_here  = upd.en && upd.idx == idx;

  // token stage and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
      valid    <= 1'b0;
      dirty    <= 1'b0;
      last_use <= '0;
    end else begin
      if (adv) begin
        scan_out <= scan_next;
      end
      if (upd_here) begin
        last_use <= upd.tick;
        if (upd.miss) begin
          valid <= 1'b1;
          dirty <= upd.write;
        end else begin
          dirty <= dirty | upd.write;
        end
      end else if (sel && adv) begin
        dirty <= 1'b0;
      end
    end
  end

  // tag store
  always_ff @(posedge clk) begin
    if (upd_here && upd.miss) begin
      tag <= upd.tag;
    end
  end

endmodule

// ----- rtl/lru_writeback_sector_cache_tags_core.sv -----
`timescale 1ns / 1ps
// lru_writeback_sector_cache_tags_core: tag and lru engine of a write-back sector cache
// depends on lwsc_pkg, lwsc_if, lwsc_cell
// an access or flush token walks one cell per cycle along the row, stalling only
// while a flush finds a dirty slot with an earlier one still waiting for the output;
// an access word comes from the finished token; clear counters skips the row;
// one item at a time
// reset clears valid, dirty, counters and the chain; no clearing pass

module lru_writeback_sector_cache_tags_core (
  input  logic       clk,
  input  logic       rst,
  lwsc_in_if.sink    in_ch,
  lwsc_out_if.source out_ch
);
  import lwsc_pkg::*;

  state_t            state, state_next;
  func_t             op;
  logic [TAG_W-1:0]  sector;
  logic [TICK_W-1:0] tick;
  logic              start;
  logic              pend_v;
  dirty_t            pend;
  logic [FCNT_W-1:0] fcnt;
  logic [CNT_W-1:0]  hit_cnt, hit_cnt_next;
  logic [CNT_W-1:0]  miss_cnt, miss_cnt_next;
  scan_t             fin;

  scan_t             chain [0:SLOTS];
  dirty_t            rpt [0:SLOTS-1];
  dirty_t            rpt_or;
  upd_t              upd;
  logic              adv, room, out_free, accept, end_hit;

  logic              out_load;
  logic [SLOT_W-1:0] o_slot;
  logic              o_hit, o_wb, o_fetch, o_last;
  logic [TAG_W-1:0]  o_wb_sector;
  logic [IDX_W-1:0]  vic;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = fcnt < FCNT_W'(MAX_RESULTS);
  assign end_hit     = chain[SLOTS].active;

  // token entering the first cell
  always_comb begin
    chain[0]        = '0;
    chain[0].active = start;
    chain[0].flush  = (op == FUNC_FLUSH);
    chain[0].sector = sector;
  end

  // row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lwsc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .adv      (adv),
      .room     (room),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .upd      (upd),
      .dirty_rpt(rpt[i])
    );
  end

  // at most one cell reports, so an or merges them
  always_comb begin
    rpt_or = '0;
    for (int i = 0; i < SLOTS; i++) begin
      rpt_or = rpt_or | rpt[i];
    end
  end

  // stall the chain while a dirty slot has nowhere to go
  assign adv = !(rpt_or.sel && pend_v && !out_free);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (func_t'(in_ch.func) == FUNC_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (end_hit) begin
          state_next = (op == FUNC_FLUSH) ? ST_FLUSH_END : ST_DONE;
        end
      end
      ST_DONE, ST_FLUSH_END: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // victim choice from the finished token
  assign vic = fin.hit ? fin.hit_idx : (fin.inv ? fin.inv_idx : fin.best_idx);

  // outputs and slot update per state
  always_comb begin
    out_load      = 1'b0;
    o_slot        = '0;
    o_hit         = 1'b0;
    o_wb          = 1'b0;
    o_wb_sector   = '0;
    o_fetch       = 1'b0;
    o_last        = 1'b0;
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    upd           = '0;
    case (state)
      ST_SCAN: begin
        // push the older pending word when a newer dirty slot turns up
        if (rpt_or.sel && pend_v && out_free) begin
          out_load    = 1'b1;
          o_slot      = SLOT_W'(pend.idx);
          o_wb        = 1'b1;
          o_wb_sector = pend.tag;
        end
      end
      ST_FLUSH_END: begin
        if (out_free) begin
          out_load = 1'b1;
          o_last   = 1'b1;
          if (pend_v) begin
            o_slot      = SLOT_W'(pend.idx);
            o_wb        = 1'b1;
            o_wb_sector = pend.tag;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_last   = 1'b1;
          if (op == FUNC_CLEAR) begin
            hit_cnt_next  = '0;
            miss_cnt_next = '0;
          end else begin
            o_slot     = SLOT_W'(vic);
            o_hit      = fin.hit;
            o_fetch    = !fin.hit;
            o_wb       = !fin.hit && !fin.inv && fin.best_dirty;
            o_wb_sector = o_wb ? fin.best_tag : '0;
            if (fin.hit) begin
              hit_cnt_next = hit_cnt + CNT_W'(1);
            end else begin
              miss_cnt_next = miss_cnt + CNT_W'(1);
            end
            upd.en    = 1'b1;
            upd.miss  = !fin.hit;
            upd.write = (op == FUNC_WRITE);
            upd.idx   = vic;
            upd.tag   = sector;
            upd.tick  = tick;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start        <= 1'b0;
      pend_v       <= 1'b0;
      fcnt         <= '0;
      hit_cnt      <= '0;
      miss_cnt     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state    <= state_next;
      start    <= accept && func_t'(in_ch.func) != FUNC_CLEAR;
      hit_cnt  <= hit_cnt_next;
      miss_cnt <= miss_cnt_next;
      if (accept) begin
        fcnt   <= '0;
        pend_v <= 1'b0;
      end else if (rpt_or.sel && adv) begin
        fcnt   <= fcnt + FCNT_W'(1);
        pend_v <= 1'b1;
      end else if (state == ST_FLUSH_END && out_free) begin
        pend_v <= 1'b0;
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= func_t'(in_ch.func);
      sector <= in_ch.sector;
      tick   <= in_ch.current_tick;
    end
    if (rpt_or.sel && adv) begin
      pend <= rpt_or;
    end
    if (state == ST_SCAN && end_hit) begin
      fin <= chain[SLOTS];
    end
    if (out_load) begin
      out_ch.slot             <= o_slot;
      out_ch.hit              <= o_hit;
      out_ch.writeback_needed <= o_wb;
      out_ch.writeback_sector <= o_wb_sector;
      out_ch.fetch_needed     <= o_fetch;
      out_ch.last             <= o_last;
      out_ch.hit_total        <= hit_cnt_next;
      out_ch.miss_total       <= miss_cnt_next;
    end
  end

endmodule

// ----- dv/lru_writeback_sector_cache_tags_core_test.sv -----
`timescale 1ns / 1ps
// lru_writeback_sector_cache_tags_core_test: self-checking bench of the sector cache tag engine
// depends on lwsc_pkg, lwsc_if and the core; predicts hit, victim, writeback and flush words

module lru_writeback_sector_cache_tags_core_test;
  import lwsc_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              wb;
    logic [TAG_W-1:0]  wb_sector;
    logic              fetch;
    logic              last;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lwsc_in_if  in_ch();
  lwsc_out_if out_ch();

  lru_writeback_sector_cache_tags_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // shadow copy of the tag array
  logic              sh_valid [SLOTS];
  logic              sh_dirty [SLOTS];
  logic [TAG_W-1:0]  sh_tag [SLOTS];
  logic [TICK_W-1:0] sh_use [SLOTS];
  logic [CNT_W-1:0]  sh_hits, sh_misses;

  word_t pending_words[$];
  int    errors = 0;
  int    words_seen = 0;
  int    items_sent = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    hold_off = 1'b0;
  longint cycles = 0;
  logic [TICK_W-1:0] tick_now = 32'd100;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch word %0d %s: got %h expected %h", words_seen, what, got, exp);
  endtask

  function automatic word_t mk(input int s, input logic h, input logic w,
                               input logic [TAG_W-1:0] ws, input logic f, input logic l);
    word_t r;
    r.slot = s[SLOT_W-1:0]; r.hit = h; r.wb = w; r.wb_sector = ws;
    r.fetch = f; r.last = l; r.hits = sh_hits; r.misses = sh_misses;
    return r;
  endfunction

  // predict the words caused by one item
  task automatic predict_access(input func_t fn, input logic [TAG_W-1:0] sec,
                                input logic [TICK_W-1:0] tk);
    int n;
    int lastk;
    int v;
    logic w;
    logic [TAG_W-1:0] old;
    n = 0; lastk = -1; v = -1;
    if (fn == FUNC_CLEAR) begin
      sh_hits = '0; sh_misses = '0;
      pending_words.push_back(mk(0, 0, 0, 0, 0, 1));
      return;
    end
    if (fn == FUNC_FLUSH) begin
      for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
        if (sh_valid[i] && sh_dirty[i]) begin
          sh_dirty[i] = 1'b0;
          pending_words.push_back(mk(i, 0, 1, sh_tag[i], 0, 0));
          n++;
        end
      end
      if (n == 0) pending_words.push_back(mk(0, 0, 0, 0, 0, 1));
      else pending_words[$].last = 1'b1;
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_valid[i] && sh_tag[i] == sec) begin
        sh_use[i] = tk;
        if (fn == FUNC_WRITE) sh_dirty[i] = 1'b1;
        sh_hits++;
        pending_words.push_back(mk(i, 1, 0, 0, 0, 1));
        return;
      end
    end
    // victim: first invalid, else oldest tick with lowest index
    for (int i = 0; i < SLOTS; i++) begin
      if (!sh_valid[i]) begin
        v = i;
        break;
      end
    end
    if (v < 0) begin
      v = 0;
      for (int i = 1; i < SLOTS; i++) if (sh_use[i] < sh_use[v]) v = i;
    end
    w = sh_valid[v] && sh_dirty[v];
    old = w ? sh_tag[v] : '0;
    sh_valid[v] = 1'b1; sh_tag[v] = sec; sh_use[v] = tk;
    sh_dirty[v] = (fn == FUNC_WRITE);
    sh_misses++;
    pending_words.push_back(mk(v, 0, w, old, 1, 1));
  endtask

  // send one word and predict on acceptance; valid drops in idle cycles
  task automatic send_item(input func_t fn, input logic [TAG_W-1:0] sec,
                           input logic [TICK_W-1:0] tk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.sector <= sec;
    in_ch.current_tick <= tk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_access(fn, sec, tk);
    items_sent++;
  endtask

  task automatic access(input func_t fn, input logic [TAG_W-1:0] sec);
    tick_now = tick_now + $urandom_range(1, 5);
    send_item(fn, sec, tick_now);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rst || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    word_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("unexpected word %0d from block", words_seen);
      end else begin
        e = pending_words.pop_front();
        if (out_ch.slot !== e.slot) report("slot", out_ch.slot, e.slot);
        if (out_ch.hit !== e.hit) report("hit", out_ch.hit, e.hit);
        if (out_ch.writeback_needed !== e.wb) report("writeback_needed", out_ch.writeback_needed, e.wb);
        if (out_ch.writeback_sector !== e.wb_sector)
          report("writeback_sector", out_ch.writeback_sector, e.wb_sector);
        if (out_ch.fetch_needed !== e.fetch) report("fetch_needed", out_ch.fetch_needed, e.fetch);
        if (out_ch.last !== e.last) report("last", out_ch.last, e.last);
        if (out_ch.hit_total !== e.hits) report("hit_total", out_ch.hit_total, e.hits);
        if (out_ch.miss_total !== e.misses) report("miss_total", out_ch.miss_total, e.misses);
      end
      words_seen++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("tb: failure");
      $finish;
    end
  end

  // directed: corner sectors and ticks, hits, flush and clear
  task automatic test_directed();
    send_item(FUNC_FLUSH, 32'h0, 32'h0);
    send_item(FUNC_READ, 32'h0, 32'h0);
    send_item(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_READ, 32'hFFFF_FFFF, 32'h1);
    send_item(FUNC_WRITE, 32'h0, 32'h2);
    send_item(FUNC_READ, 32'hAAAA_5555, 32'h0);
    send_item(FUNC_CLEAR, 32'h5555_AAAA, 32'hFFFF_FFFF);
    send_item(FUNC_FLUSH, 32'h1234, 32'h0);
    send_item(FUNC_FLUSH, 32'h0, 32'h0);
    send_item(FUNC_WRITE, 32'h5555_AAAA, 32'hAAAA_5555);
  endtask

  // fill every slot dirty, then evict and flush all 64
  task automatic test_full_cache();
    for (int i = 0; i < SLOTS; i++) access(FUNC_WRITE, 32'h1000 + i);
    access(FUNC_READ, 32'h1000 + 3);
    access(FUNC_WRITE, 32'h9999);
    access(FUNC_READ, 32'h8888);
    send_item(FUNC_FLUSH, 0, 0);
    for (int i = 0; i < SLOTS; i++) access(FUNC_WRITE, 32'h2000 + i);
    send_item(FUNC_FLUSH, 0, 0);
    drain();
  endtask

  // random flushes, clears and accesses on a small sector pool so hits and evictions happen
  task automatic test_random(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 4) send_item(FUNC_FLUSH, $urandom, $urandom);
      else if (r < 6) send_item(FUNC_CLEAR, $urandom, $urandom);
      else if (r < 12) send_item(r[0] ? FUNC_WRITE : FUNC_READ, $urandom, $urandom);
      else access(r[1] ? FUNC_WRITE : FUNC_READ, 32'h3000 + $urandom_range(90));
    end
    drain();
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int k = 0; k < 10; k++) access(FUNC_WRITE, 32'h3000 + $urandom_range(90));
        send_item(FUNC_FLUSH, 0, 0);
        drain();
      end
    join
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_READ;
    in_ch.sector = '0;
    in_ch.current_tick = '0;
    sh_hits = '0; sh_misses = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 0; sh_dirty[i] = 0; sh_tag[i] = '0; sh_use[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 31; recv_idle_pct = 49;
    test_directed();
    test_full_cache();
    test_random(8);
    send_idle_pct = 49; recv_idle_pct = 31;
    test_backpressure();
    test_random(8);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(6);
    drain();
    $display("covered %0d items, %0d words: hits, lru and dirty evictions, flush, clear",
             items_sent, words_seen);
    $display("ran with random idling on both sides and one long output stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lwsc_pkg.sv
rtl/lwsc_if.sv
rtl/lwsc_cell.sv
rtl/lru_writeback_sector_cache_tags_core.sv
dv/lru_writeback_sector_cache_tags_core_test.sv
